// ===== rtl/link_packet_deframer_assert.svh =====
// Assertion macros shared by the link packet deframer RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef LINK_PACKET_DEFRAMER_ASSERT_SVH
`define LINK_PACKET_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LPD_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lpd: forbidden condition seen");
`define LPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpd: implication failed");
`define LPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpd: next-cycle implication failed");
`else
`define LPD_ASSERT_NEVER(lbl, cond)
`define LPD_ASSERT_IMPL(lbl, ante, cons)
`define LPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/lpd_pkg.sv =====
// Package for the link packet deframer: event kinds, header positions,
// packet types and the command passed from the front end to the back end.
`default_nettype none
package lpd_pkg;

    typedef enum logic [2:0] {
        KIND_SIZE     = 3'd0,
        KIND_TYPE     = 3'd1,
        KIND_ACK      = 3'd2,
        KIND_BUFSIZE  = 3'd3,
        KIND_VSIZE    = 3'd4,
        KIND_VCODE    = 3'd5,
        KIND_PAYLOAD  = 3'd6
    } kind_t;

    localparam logic [3:0] POS_SIZE0   = 4'd1;
    localparam logic [3:0] POS_SIZE1   = 4'd2;
    localparam logic [3:0] POS_SIZE2   = 4'd3;
    localparam logic [3:0] POS_SIZE3   = 4'd4;
    localparam logic [3:0] POS_TYPE    = 4'd5;
    localparam logic [3:0] POS_HDR6    = 4'd6;
    localparam logic [3:0] POS_HDR7    = 4'd7;
    localparam logic [3:0] POS_HDR8    = 4'd8;
    localparam logic [3:0] POS_HDR9    = 4'd9;
    localparam logic [3:0] POS_HDR10   = 4'd10;
    localparam logic [3:0] POS_HDR11   = 4'd11;
    localparam logic [3:0] POS_PAYLOAD = 4'd12;

    localparam logic [7:0] TYPE_BUF_A  = 8'd1;
    localparam logic [7:0] TYPE_BUF_B  = 8'd2;
    localparam logic [7:0] TYPE_VCONT  = 8'd3;
    localparam logic [7:0] TYPE_VLAST  = 8'd4;
    localparam logic [7:0] TYPE_ACK    = 8'd5;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic        multi;
        logic        pkt_end;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/lpd_front.sv =====
// Front end of the link packet deframer: header tracking and classification.
// Depends on lpd_pkg; emits one command per byte that yields results.
`default_nettype none
module lpd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          q_full,
    output logic               q_wr,
    output lpd_pkg::cmd_t      q_cmd
);
    import lpd_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    logic [31:0] recent_reg, recent_next;
    logic [7:0]  ptype_reg, ptype_next;
    logic [31:0] rem_reg, rem_next;
    logic        vzero_reg, vzero_next;
    logic        expnew_reg, expnew_next;
    logic        emit;
    logic        end_pkt;
    logic        accept;
    logic [31:0] rem_dec1, rem_dec4, rem_dec6;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign rem_dec1 = (rem_reg > 32'd1) ? rem_reg - 32'd1 : 32'd0;
    assign rem_dec4 = (rem_reg > 32'd4) ? rem_reg - 32'd4 : 32'd0;
    assign rem_dec6 = (rem_reg > 32'd6) ? rem_reg - 32'd6 : 32'd0;

    always_comb
    begin
        recent_next = {recent_reg[23:0], in_byte};
        pos_next    = pos_reg;
        ptype_next  = ptype_reg;
        rem_next    = rem_reg;
        vzero_next  = vzero_reg;
        expnew_next = expnew_reg;
        emit        = 1'b0;
        end_pkt     = 1'b0;
        q_cmd       = '{kind: KIND_PAYLOAD, value: {24'd0, in_byte}, multi: 1'b0,
                        pkt_end: 1'b0};
        case (pos_reg)
            POS_SIZE0, POS_SIZE1, POS_SIZE2, POS_HDR6, POS_HDR8, POS_HDR10:
            begin
                pos_next = pos_reg + 4'd1;
            end
            POS_SIZE3:
            begin
                emit        = 1'b1;
                q_cmd.kind  = KIND_SIZE;
                q_cmd.value = recent_next;
                rem_next    = recent_next;
                pos_next    = POS_TYPE;
            end
            POS_TYPE:
            begin
                emit       = 1'b1;
                q_cmd.kind = KIND_TYPE;
                ptype_next = in_byte;
                if (in_byte inside {[TYPE_BUF_A:TYPE_ACK]})
                    pos_next = POS_HDR6;
                else if (rem_reg == 32'd0)
                    end_pkt = 1'b1;
                else
                    pos_next = POS_PAYLOAD;
            end
            POS_HDR7:
            begin
                if (ptype_reg == TYPE_ACK)
                begin
                    emit        = 1'b1;
                    q_cmd.kind  = KIND_ACK;
                    q_cmd.value = {16'd0, recent_next[15:0]};
                    end_pkt     = 1'b1;
                end
                else
                begin
                    pos_next = POS_HDR8;
                end
            end
            POS_HDR9:
            begin
                emit        = 1'b1;
                q_cmd.value = recent_next;
                if (ptype_reg == TYPE_BUF_A || ptype_reg == TYPE_BUF_B)
                begin
                    q_cmd.kind = KIND_BUFSIZE;
                    end_pkt    = 1'b1;
                end
                else if (expnew_reg)
                begin
                    q_cmd.kind  = KIND_VSIZE;
                    vzero_next  = (recent_next == 32'd0);
                    rem_next    = rem_dec6;
                    expnew_next = (ptype_reg == TYPE_VLAST);
                    pos_next    = POS_HDR10;
                end
                else
                begin
                    q_cmd.multi = 1'b1;
                    rem_next    = rem_dec4;
                    expnew_next = (ptype_reg == TYPE_VLAST);
                    end_pkt     = (rem_dec4 == 32'd0);
                    pos_next    = POS_PAYLOAD;
                end
            end
            POS_HDR11:
            begin
                emit        = 1'b1;
                q_cmd.kind  = KIND_VCODE;
                q_cmd.value = {16'd0, recent_next[15:0]};
                if (vzero_reg || rem_reg == 32'd0)
                    end_pkt = 1'b1;
                else
                    pos_next = POS_PAYLOAD;
            end
            default:
            begin
                emit     = 1'b1;
                rem_next = rem_dec1;
                end_pkt  = (rem_dec1 == 32'd0);
                pos_next = POS_PAYLOAD;
            end
        endcase
        if (end_pkt)
            pos_next = POS_SIZE0;
        q_cmd.pkt_end = end_pkt;
    end

    assign q_wr = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_SIZE0;
            recent_reg <= 32'd0;
            ptype_reg  <= 8'd0;
            rem_reg    <= 32'd0;
            vzero_reg  <= 1'b0;
            expnew_reg <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            recent_reg <= recent_next;
            ptype_reg  <= ptype_next;
            rem_reg    <= rem_next;
            vzero_reg  <= vzero_next;
            expnew_reg <= expnew_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lpd_fifo.sv =====
// Command queue between front and back end of the link packet deframer.
// Depends on lpd_pkg for the command type and depth.
`default_nettype none
`include "link_packet_deframer_assert.svh"
module lpd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire lpd_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd,
    output lpd_pkg::cmd_t      rd_data,
    output logic               empty
);
    import lpd_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `LPD_ASSERT_NEVER(a_no_overflow, wr && full)
    `LPD_ASSERT_NEVER(a_no_underflow, rd && empty)
    `LPD_ASSERT_IMPL(a_ptr_match, empty || full, wr_ptr_reg == rd_ptr_reg)

endmodule
`default_nettype wire

// ===== rtl/lpd_back.sv =====
// Back end of the link packet deframer: expands queued commands into beats.
// Depends on lpd_pkg; drives the registered result channel.
`default_nettype none
`include "link_packet_deframer_assert.svh"
module lpd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lpd_pkg::cmd_t q_cmd,
    input  wire logic          q_empty,
    output logic               q_rd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         out_kind,
    output logic [31:0]        out_value,
    output logic               out_end,
    output logic               out_last
);
    import lpd_pkg::*;

    logic        valid_reg;
    logic [1:0]  sub_reg;
    logic [2:0]  kind_reg;
    logic [31:0] value_reg;
    logic        end_reg;
    logic        last_reg;
    logic        load;
    logic        final_sub;
    logic [7:0]  sel_byte;

    assign load      = !q_empty && (!valid_reg || out_ready);
    assign final_sub = !q_cmd.multi || (sub_reg == 2'd3);
    assign q_rd      = load && final_sub;

    always_comb
    begin
        case (sub_reg)
            2'd0:    sel_byte = q_cmd.value[31:24];
            2'd1:    sel_byte = q_cmd.value[23:16];
            2'd2:    sel_byte = q_cmd.value[15:8];
            default: sel_byte = q_cmd.value[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            sub_reg   <= final_sub ? 2'd0 : sub_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= q_cmd.multi ? KIND_PAYLOAD : q_cmd.kind;
            value_reg <= q_cmd.multi ? {24'd0, sel_byte} : q_cmd.value;
            end_reg   <= q_cmd.pkt_end && final_sub;
            last_reg  <= final_sub;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_end   = end_reg;
    assign out_last  = last_reg;

    `LPD_ASSERT_IMPL(a_end_on_last, valid_reg && end_reg, last_reg)
    `LPD_ASSERT_IMPL(a_sub_needs_multi, sub_reg != 2'd0, valid_reg && !last_reg)
    `LPD_ASSERT_NEXT(a_sub_steps, load && !final_sub, sub_reg == $past(sub_reg) + 2'd1)

endmodule
`default_nettype wire

// ===== rtl/link_packet_deframer.sv =====
// Link packet deframer: one byte accepted per cycle while the queue has room.
// A result beat passes through the command queue and then the back-end output register after its byte is accepted.
// The back end drives one beat per cycle while out_ready is high; a continuation header byte yields four beats.
// The four-entry command queue sets how long a stalled output is absorbed.
// rst_n clears header tracking, continuation flag and queue asynchronously.
`default_nettype none
module link_packet_deframer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,    // data_byte[7:0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [39:0]        m_tdata,    // event_kind[2:0], event_value[34:3], zero
    output logic               m_tlast,
    output logic               m_tuser     // last_of_run
);
    import lpd_pkg::*;

    cmd_t        wr_cmd;
    cmd_t        rd_cmd;
    logic        q_wr;
    logic        q_rd;
    logic        q_full;
    logic        q_empty;
    logic [2:0]  kind;
    logic [31:0] value;

    lpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_cmd    (wr_cmd)
    );

    lpd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (wr_cmd),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (rd_cmd),
        .empty   (q_empty)
    );

    lpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (rd_cmd),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (kind),
        .out_value (value),
        .out_end   (m_tlast),
        .out_last  (m_tuser)
    );

    assign m_tdata = {5'd0, value, kind};

endmodule
`default_nettype wire

// ===== tb/link_packet_deframer_tb.sv =====
// Self-checking testbench for link_packet_deframer: streams framed and broken link packets.
// A scoreboard class predicts every event beat from the byte stream. Needs lpd_pkg and the RTL.
`default_nettype none

typedef struct {
    lpd_pkg::kind_t kind;
    logic [31:0]    value;
    bit             pkt_end;
    bit             run_end;
} deframer_beat_t;

class deframer_scoreboard;
    logic [3:0]     hdr_pos;
    logic [31:0]    last_four;
    logic [7:0]     pkt_type;
    logic [31:0]    bytes_owed;
    bit             vsize_zero;
    bit             first_frag_due;
    deframer_beat_t run_beats[$];
    deframer_beat_t expected_beats[$];
    int             errors;

    function new();
        hdr_pos        = lpd_pkg::POS_SIZE0;
        last_four      = '0;
        pkt_type       = '0;
        bytes_owed     = '0;
        vsize_zero     = 1'b0;
        first_frag_due = 1'b1;
        errors         = 0;
    endfunction

    function logic [31:0] owed_minus(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    function void add_beat(lpd_pkg::kind_t kind, logic [31:0] value);
        deframer_beat_t beat;
        beat.kind    = kind;
        beat.value   = value;
        beat.pkt_end = 1'b0;
        beat.run_end = 1'b0;
        run_beats.push_back(beat);
    endfunction

    function void note_byte(logic [7:0] b);
        bit closes;
        closes = 1'b0;
        run_beats.delete();
        last_four = {last_four[23:0], b};
        case (hdr_pos)
            lpd_pkg::POS_SIZE0, lpd_pkg::POS_SIZE1, lpd_pkg::POS_SIZE2,
            lpd_pkg::POS_HDR6, lpd_pkg::POS_HDR8, lpd_pkg::POS_HDR10:
                hdr_pos = hdr_pos + 4'd1;
            lpd_pkg::POS_SIZE3:
            begin
                add_beat(lpd_pkg::KIND_SIZE, last_four);
                bytes_owed = last_four;
                hdr_pos    = lpd_pkg::POS_TYPE;
            end
            lpd_pkg::POS_TYPE:
            begin
                pkt_type = b;
                add_beat(lpd_pkg::KIND_TYPE, {24'd0, b});
                if (b >= lpd_pkg::TYPE_BUF_A && b <= lpd_pkg::TYPE_ACK)
                    hdr_pos = lpd_pkg::POS_HDR6;
                else if (bytes_owed == 32'd0)
                    closes = 1'b1;
                else
                    hdr_pos = lpd_pkg::POS_PAYLOAD;
            end
            lpd_pkg::POS_HDR7:
            begin
                if (pkt_type == lpd_pkg::TYPE_ACK)
                begin
                    add_beat(lpd_pkg::KIND_ACK, {16'd0, last_four[15:0]});
                    closes = 1'b1;
                end
                else
                begin
                    hdr_pos = lpd_pkg::POS_HDR8;
                end
            end
            lpd_pkg::POS_HDR9:
            begin
                if (pkt_type == lpd_pkg::TYPE_BUF_A || pkt_type == lpd_pkg::TYPE_BUF_B)
                begin
                    add_beat(lpd_pkg::KIND_BUFSIZE, last_four);
                    closes = 1'b1;
                end
                else if (first_frag_due)
                begin
                    add_beat(lpd_pkg::KIND_VSIZE, last_four);
                    vsize_zero     = (last_four == 32'd0);
                    bytes_owed     = owed_minus(bytes_owed, 32'd6);
                    first_frag_due = (pkt_type == lpd_pkg::TYPE_VLAST);
                    hdr_pos        = lpd_pkg::POS_HDR10;
                end
                else
                begin
                    add_beat(lpd_pkg::KIND_PAYLOAD, {24'd0, last_four[31:24]});
                    add_beat(lpd_pkg::KIND_PAYLOAD, {24'd0, last_four[23:16]});
                    add_beat(lpd_pkg::KIND_PAYLOAD, {24'd0, last_four[15:8]});
                    add_beat(lpd_pkg::KIND_PAYLOAD, {24'd0, b});
                    bytes_owed     = owed_minus(bytes_owed, 32'd3);
                    first_frag_due = (pkt_type == lpd_pkg::TYPE_VLAST);
                    bytes_owed     = owed_minus(bytes_owed, 32'd1);
                    closes         = (bytes_owed == 32'd0);
                    hdr_pos        = lpd_pkg::POS_PAYLOAD;
                end
            end
            lpd_pkg::POS_HDR11:
            begin
                add_beat(lpd_pkg::KIND_VCODE, {16'd0, last_four[15:0]});
                if (vsize_zero || bytes_owed == 32'd0)
                    closes = 1'b1;
                else
                    hdr_pos = lpd_pkg::POS_PAYLOAD;
            end
            default:
            begin
                add_beat(lpd_pkg::KIND_PAYLOAD, {24'd0, b});
                bytes_owed = owed_minus(bytes_owed, 32'd1);
                closes     = (bytes_owed == 32'd0);
                hdr_pos    = lpd_pkg::POS_PAYLOAD;
            end
        endcase
        if (closes)
            hdr_pos = lpd_pkg::POS_SIZE0;
        if (run_beats.size() > 0)
        begin
            run_beats[run_beats.size() - 1].run_end = 1'b1;
            run_beats[run_beats.size() - 1].pkt_end = closes;
        end
        foreach (run_beats[i])
            expected_beats.push_back(run_beats[i]);
    endfunction

    function void check_beat(logic [39:0] data, logic last, logic user);
        deframer_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected beat: kind %0d value %h", data[2:0], data[34:3]);
            errors++;
            return;
        end
        want = expected_beats.pop_front();
        if (data[2:0] !== want.kind)
        begin
            $error("event_kind: expected %0d, got %0d", want.kind, data[2:0]);
            errors++;
        end
        if (data[34:3] !== want.value)
        begin
            $error("event_value: expected %h, got %h", want.value, data[34:3]);
            errors++;
        end
        if (data[39:35] !== 5'd0)
        begin
            $error("tdata padding: expected %h, got %h", 5'd0, data[39:35]);
            errors++;
        end
        if (last !== want.pkt_end)
        begin
            $error("packet_end: expected %0d, got %0d", want.pkt_end, last);
            errors++;
        end
        if (user !== want.run_end)
        begin
            $error("last_of_run: expected %0d, got %0d", want.run_end, user);
            errors++;
        end
    endfunction
endclass

module link_packet_deframer_tb;
    import lpd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_TARGET = 430;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    deframer_scoreboard sb;
    logic [7:0]         frame[$];
    int                 bytes_sent;
    bit                 full_speed;
    int                 quiet_cycles;

    link_packet_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (full_speed || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(9, 40);
        return $urandom_range(0, 8);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
        frame.delete();
    endtask

    task automatic put_word(input logic [31:0] w);
        frame.push_back(w[31:24]);
        frame.push_back(w[23:16]);
        frame.push_back(w[15:8]);
        frame.push_back(w[7:0]);
    endtask

    // Header is written after the body is known, so build the body first.
    task automatic build_random_frame();
        logic [7:0]  body[$];
        logic [7:0]  ptype;
        logic [31:0] size;
        logic [31:0] vsize;
        int          choice;
        int          plen;
        int          k;
        bit          broken;
        choice = $urandom_range(0, 99);
        broken = ($urandom_range(0, 9) == 0);
        plen   = 0;
        if (choice < 15)
        begin
            ptype = TYPE_ACK;
            body.push_back($urandom_range(0, 255));
            body.push_back($urandom_range(0, 255));
            size = broken ? $urandom : 32'd2;
            broken = 1'b0;
        end
        else if (choice < 30)
        begin
            ptype = $urandom_range(0, 1) ? TYPE_BUF_A : TYPE_BUF_B;
            vsize = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
            body.push_back(vsize[31:24]);
            body.push_back(vsize[23:16]);
            body.push_back(vsize[15:8]);
            body.push_back(vsize[7:0]);
            size = broken ? $urandom : 32'd4;
            broken = 1'b0;
        end
        else if (choice < 80)
        begin
            ptype = $urandom_range(0, 1) ? TYPE_VCONT : TYPE_VLAST;
            plen  = pick_len();
            if (sb.first_frag_due)
            begin
                case ($urandom_range(0, 5))
                    0:       vsize = 32'd0;
                    1:       vsize = $urandom_range(1, 64);
                    default: vsize = $urandom;
                endcase
                if (vsize == 32'd0)
                    plen = 0;
                body.push_back(vsize[31:24]);
                body.push_back(vsize[23:16]);
                body.push_back(vsize[15:8]);
                body.push_back(vsize[7:0]);
                body.push_back($urandom_range(0, 255));
                body.push_back($urandom_range(0, 255));
                size = 32'd6 + plen;
                if (broken && plen == 0)
                    size = $urandom_range(0, 5);
            end
            else
            begin
                repeat (4) body.push_back($urandom_range(0, 255));
                size = 32'd4 + plen;
                if (broken && plen == 0)
                    size = $urandom_range(0, 3);
            end
            repeat (plen) body.push_back($urandom_range(0, 255));
        end
        else
        begin
            do
                ptype = $urandom_range(0, 255);
            while (ptype >= TYPE_BUF_A && ptype <= TYPE_ACK);
            plen = pick_len();
            repeat (plen) body.push_back($urandom_range(0, 255));
            size = plen;
        end
        // Short size: the zeroed tail becomes a zero-size header that resync completes.
        if (broken && plen > 0)
        begin
            k = $urandom_range(1, (plen < 3) ? plen : 3);
            size = size - k;
            for (int i = 0; i < k; i++)
                body[body.size() - 1 - i] = 8'd0;
        end
        put_word(size);
        frame.push_back(ptype);
        foreach (body[i])
            frame.push_back(body[i]);
    endtask

    task automatic resync();
        int guard;
        guard = 0;
        while (sb.hdr_pos != POS_SIZE0 && guard < 16)
        begin
            send_byte(8'd0);
            guard++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata, m_tlast, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[link_packet_deframer] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : ready_gen
        int len;
        wait (rst_n === 1'b1);
        forever
        begin
            if (full_speed)
            begin
                m_tready <= 1'b1;
                len = 1;
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                len = $urandom_range(1, 12);
            end
            else
            begin
                m_tready <= 1'b0;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
            end
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        m_tready     = 1'b0;
        bytes_sent   = 0;
        full_speed   = 1'b0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-ones size and buffer size
        put_word(32'hFFFF_FFFF);
        frame.push_back(TYPE_BUF_A);
        put_word(32'hFFFF_FFFF);
        send_frame();
        // unknown type, zero size: ends on the type byte
        put_word(32'd0);
        frame.push_back(8'd0);
        send_frame();
        put_word(32'd2);
        frame.push_back(TYPE_ACK);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        send_frame();
        put_word(32'd1);
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        send_frame();

        while (bytes_sent < BYTE_TARGET)
        begin
            full_speed = ($urandom_range(0, 4) == 0);
            build_random_frame();
            send_frame();
            resync();
        end
        s_tvalid   <= 1'b0;
        full_speed = 1'b0;

        while (sb.expected_beats.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("[link_packet_deframer] OK");
        else
            $display("[link_packet_deframer] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
